// ===== sv/thb_pkg.sv =====
// Shared types and constants for the timestamped history buffer.
// No dependencies.
package thb_pkg;

  localparam int unsigned WORD_W = 64;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_DISCARD = 2'd2,
    OP_IGNORE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EARLY = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_SCAN  = 3'd1,
    S_EMIT  = 3'd2,
    S_LOAD  = 3'd3,
    S_CLEAR = 3'd4
  } fsm_e;

endpackage

// ===== sv/thb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module thb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/timestamped_history_buffer_top.sv =====
// Top level of the timestamped history buffer: control, scan and output register.
// Depends on thb_pkg and thb_ram (time memory and element memory).
//
// Usage:
//   Input beats carry an operation: append one element (the beat with
//   final_element_i set commits the entry), query at a time, or discard
//   before a time. Output beats carry status, entry stamp, one element pair
//   and last_out_o on the final beat caused by an input beat.
//   Appends: a non-final element gives no output; the final element gives one
//   output beat in the next cycle. A short entry then has its missing elements
//   zeroed, one per cycle, before the next input beat is taken.
//   Query: scans stored times newest first, one entry per cycle through the
//   time memory read port, then streams DOFS beats through the element memory
//   read port; each beat waits in S_EMIT for a free output register.
//   Discard: same scan, then one output beat.
//   Empty ring: query or discard gives one beat in the next cycle.
//   Inputs are taken only in the idle state with the output register free or
//   being drained. A stalled receiver holds the output register and the
//   block waits. Reset empties the ring; memory contents are kept as is.
module timestamped_history_buffer_top
  import thb_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DOFS  = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic signed [WORD_W-1:0] stamp_i,
  input  logic [WORD_W-1:0]        position_word_i,
  input  logic [WORD_W-1:0]        velocity_word_i,
  input  logic                     final_element_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [WORD_W-1:0] entry_stamp_o,
  output logic [WORD_W-1:0]        position_out_o,
  output logic [WORD_W-1:0]        velocity_out_o,
  output logic                     last_out_o
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned KW = $clog2(DEPTH + 1);
  localparam int unsigned CW = $clog2(DOFS + 1);
  localparam int unsigned EW = (DOFS > 1) ? $clog2(DOFS) : 1;
  localparam int unsigned AW = $clog2(DEPTH * DOFS);
  localparam int unsigned TW = WORD_W + CW;

  localparam logic [SW-1:0] SLOT_LAST = SW'(DEPTH - 1);
  localparam logic [KW-1:0] COUNT_MAX = KW'(DEPTH);
  localparam logic [AW-1:0] BASE_LAST = AW'((DEPTH - 1) * DOFS);
  localparam logic [AW-1:0] BASE_STEP = AW'(DOFS);
  localparam logic [CW-1:0] FILL_MAX  = CW'(DOFS);
  localparam logic [EW-1:0] ELEM_LAST = EW'(DOFS - 1);
  localparam logic [KW-1:0] K_ONE     = KW'(1);

  fsm_e                     state_q, state_d;
  logic [KW-1:0]            count_q, count_d;
  logic [SW-1:0]            tail_q, tail_d;
  logic [AW-1:0]            tail_base_q, tail_base_d;
  logic [CW-1:0]            fill_q, fill_d;
  op_e                      op_q, op_d;
  logic signed [WORD_W-1:0] key_q, key_d;
  logic [KW-1:0]            iss_k_q, iss_k_d;
  logic [SW-1:0]            iss_slot_q, iss_slot_d;
  logic [AW-1:0]            iss_base_q, iss_base_d;
  logic                     rv_q, rv_d;
  logic [KW-1:0]            rk_q, rk_d;
  logic [AW-1:0]            rbase_q, rbase_d;
  logic [AW-1:0]            ent_base_q, ent_base_d;
  logic [CW-1:0]            ent_cnt_q, ent_cnt_d;
  logic signed [WORD_W-1:0] ent_stamp_q, ent_stamp_d;
  status_e                  ent_status_q, ent_status_d;
  logic [EW-1:0]            elem_q, elem_d;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  logic signed [WORD_W-1:0] out_stamp_q;
  logic [WORD_W-1:0]        out_pos_q, out_vel_q;
  logic                     out_last_q;

  logic                     ld;
  status_e                  ld_status;
  logic signed [WORD_W-1:0] ld_stamp;
  logic [WORD_W-1:0]        ld_pos, ld_vel;
  logic                     ld_last;

  logic                     t_we, t_re;
  logic [SW-1:0]            t_waddr, t_raddr;
  logic [TW-1:0]            t_wdata, t_rdata;
  logic                     e_we, e_re;
  logic [AW-1:0]            e_waddr, e_raddr;
  logic [2*WORD_W-1:0]      e_wdata, e_rdata;

  logic                     out_free, accept;
  logic                     full;
  logic [CW-1:0]            fill_nx;
  logic signed [WORD_W-1:0] r_time;
  logic [CW-1:0]            r_cnt;
  logic                     r_le;

  thb_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  thb_ram #(.WIDTH(2 * WORD_W), .DEPTH(DEPTH * DOFS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == COUNT_MAX);
  assign fill_nx    = (fill_q < FILL_MAX) ? fill_q + CW'(1) : fill_q;
  assign r_time     = t_rdata[WORD_W-1:0];
  assign r_cnt      = t_rdata[TW-1:WORD_W];
  assign r_le       = (op_q == OP_QUERY) ? (r_time <= key_q) : (r_time < key_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    tail_d       = tail_q;
    tail_base_d  = tail_base_q;
    fill_d       = fill_q;
    op_d         = op_q;
    key_d        = key_q;
    iss_k_d      = iss_k_q;
    iss_slot_d   = iss_slot_q;
    iss_base_d   = iss_base_q;
    rv_d         = 1'b0;
    rk_d         = rk_q;
    rbase_d      = rbase_q;
    ent_base_d   = ent_base_q;
    ent_cnt_d    = ent_cnt_q;
    ent_stamp_d  = ent_stamp_q;
    ent_status_d = ent_status_q;
    elem_d       = elem_q;

    ld        = 1'b0;
    ld_status = STAT_OK;
    ld_stamp  = '0;
    ld_pos    = '0;
    ld_vel    = '0;
    ld_last   = 1'b1;

    t_we    = 1'b0;
    t_waddr = tail_q;
    t_wdata = {fill_nx, stamp_i};
    t_re    = 1'b0;
    t_raddr = iss_slot_q;
    e_we    = 1'b0;
    e_waddr = tail_base_q + AW'(fill_q);
    e_wdata = {velocity_word_i, position_word_i};
    e_re    = 1'b0;
    e_raddr = ent_base_q + AW'(elem_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_APPEND: begin
              e_we   = !full && (fill_q < FILL_MAX);
              fill_d = fill_nx;
              if (final_element_i) begin
                fill_d = '0;
                ld     = 1'b1;
                if (full) begin
                  ld_status = STAT_FULL;
                end else begin
                  ld_stamp    = stamp_i;
                  t_we        = 1'b1;
                  count_d     = count_q + KW'(1);
                  tail_d      = (tail_q == SLOT_LAST) ? '0 : tail_q + SW'(1);
                  tail_base_d = (tail_base_q == BASE_LAST) ? '0 : tail_base_q + BASE_STEP;
                  if (fill_nx < FILL_MAX) begin
                    ent_base_d = tail_base_q;
                    elem_d     = EW'(fill_nx);
                    state_d    = S_CLEAR;
                  end
                end
              end
            end
            OP_QUERY, OP_DISCARD: begin
              if (count_q == '0) begin
                ld        = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                op_d       = op_e'(operation_i);
                key_d      = stamp_i;
                iss_k_d    = count_q;
                iss_slot_d = (tail_q == '0) ? SLOT_LAST : tail_q - SW'(1);
                iss_base_d = (tail_base_q == '0) ? BASE_LAST : tail_base_q - BASE_STEP;
                state_d    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_k_q != '0) begin
          t_re       = 1'b1;
          rv_d       = 1'b1;
          rk_d       = iss_k_q;
          rbase_d    = iss_base_q;
          iss_k_d    = iss_k_q - KW'(1);
          iss_slot_d = (iss_slot_q == '0) ? SLOT_LAST : iss_slot_q - SW'(1);
          iss_base_d = (iss_base_q == '0) ? BASE_LAST : iss_base_q - BASE_STEP;
        end
        if (rv_q && (r_le || rk_q == K_ONE)) begin
          if (op_q == OP_QUERY) begin
            ent_base_d   = rbase_q;
            ent_cnt_d    = r_cnt;
            ent_stamp_d  = r_time;
            ent_status_d = r_le ? STAT_OK : STAT_EARLY;
            elem_d       = '0;
            state_d      = S_EMIT;
          end else begin
            if (r_le) begin
              count_d = count_q - rk_q;
            end
            ld      = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          e_re    = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        ld        = 1'b1;
        ld_status = ent_status_q;
        ld_stamp  = ent_stamp_q;
        if (CW'(elem_q) < ent_cnt_q) begin
          ld_pos = e_rdata[WORD_W-1:0];
          ld_vel = e_rdata[2*WORD_W-1:WORD_W];
        end
        ld_last = (elem_q == ELEM_LAST);
        if (elem_q == ELEM_LAST) begin
          state_d = S_IDLE;
        end else begin
          elem_d  = elem_q + EW'(1);
          state_d = S_EMIT;
        end
      end
      S_CLEAR: begin
        // zero the elements a short entry never delivered
        e_we    = 1'b1;
        e_waddr = ent_base_q + AW'(elem_q);
        e_wdata = '0;
        if (elem_q == ELEM_LAST) begin
          state_d = S_IDLE;
        end else begin
          elem_d = elem_q + EW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = ld || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tail_q      <= '0;
      tail_base_q <= '0;
      fill_q      <= '0;
      iss_k_q     <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tail_q      <= tail_d;
      tail_base_q <= tail_base_d;
      fill_q      <= fill_d;
      iss_k_q     <= iss_k_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    iss_slot_q   <= iss_slot_d;
    iss_base_q   <= iss_base_d;
    rk_q         <= rk_d;
    rbase_q      <= rbase_d;
    ent_base_q   <= ent_base_d;
    ent_cnt_q    <= ent_cnt_d;
    ent_stamp_q  <= ent_stamp_d;
    ent_status_q <= ent_status_d;
    elem_q       <= elem_d;
    if (ld) begin
      out_status_q <= ld_status;
      out_stamp_q  <= ld_stamp;
      out_pos_q    <= ld_pos;
      out_vel_q    <= ld_vel;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entry_stamp_o  = out_stamp_q;
  assign position_out_o = out_pos_q;
  assign velocity_out_o = out_vel_q;
  assign last_out_o     = out_last_q;

endmodule

// ===== verif/timestamped_history_buffer_top_test.sv =====
// Self-checking bench for timestamped_history_buffer_top: directed and random
// append, query and discard beats, checked against an in-bench ring model.
// Depends on thb_pkg and the buffer RTL.
module timestamped_history_buffer_top_test
  import thb_pkg::*;
();

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned DOFS         = 8;
  localparam int          RAND_BEATS   = 235;
  localparam int          FILL_AFTER   = 100;
  localparam int          CALM_TAIL    = 40;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          MAX_REPORTS  = 10;
  localparam int          HIST_KEEP    = 80;
  localparam logic signed [WORD_W-1:0] T_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] T_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct {
    op_e                      op;
    logic signed [WORD_W-1:0] stamp;
    logic [WORD_W-1:0]        pos;
    logic [WORD_W-1:0]        vel;
    logic                     fin;
  } beat_t;

  typedef struct {
    status_e                  status;
    logic signed [WORD_W-1:0] stamp;
    logic [WORD_W-1:0]        pos;
    logic [WORD_W-1:0]        vel;
    logic                     last;
  } result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               operation_i = OP_IGNORE;
  logic signed [WORD_W-1:0] stamp_i = '0;
  logic [WORD_W-1:0]        position_word_i = '0;
  logic [WORD_W-1:0]        velocity_word_i = '0;
  logic                     final_element_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [WORD_W-1:0] entry_stamp_o;
  logic [WORD_W-1:0]        position_out_o;
  logic [WORD_W-1:0]        velocity_out_o;
  logic                     last_out_o;

  timestamped_history_buffer_top #(
    .DEPTH(DEPTH),
    .DOFS (DOFS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .stamp_i        (stamp_i),
    .position_word_i(position_word_i),
    .velocity_word_i(velocity_word_i),
    .final_element_i(final_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .entry_stamp_o  (entry_stamp_o),
    .position_out_o (position_out_o),
    .velocity_out_o (velocity_out_o),
    .last_out_o     (last_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ring model state
  logic signed [WORD_W-1:0] ring_time [DEPTH];
  logic [WORD_W-1:0]        ring_pos  [DEPTH*DOFS];
  logic [WORD_W-1:0]        ring_vel  [DEPTH*DOFS];
  int unsigned              ring_oldest = 0;
  int unsigned              ring_count  = 0;
  int unsigned              ring_fill   = 0;

  beat_t                    beats_to_send[$];
  result_t                  results_due[$];
  logic signed [WORD_W-1:0] stamp_hist[$];
  logic signed [WORD_W-1:0] stamp_clock = -64'sd2000;
  beat_t                    on_wire;
  int                       tx_gap = 0;
  int                       rx_stall = 0;
  bit                       calm_phase = 1'b0;
  int                       n_mismatch = 0;
  int                       cycles = 0;

  function automatic result_t mk_result(status_e s, logic signed [WORD_W-1:0] t,
                                        logic [WORD_W-1:0] p, logic [WORD_W-1:0] v,
                                        logic l);
    result_t r;
    r.status = s;
    r.stamp  = t;
    r.pos    = p;
    r.vel    = v;
    r.last   = l;
    return r;
  endfunction

  function automatic void queue_result(result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  task automatic stream_entry(int unsigned slot, status_e s);
    for (int unsigned e = 0; e < DOFS; e++)
      queue_result(mk_result(s, ring_time[slot], ring_pos[slot*DOFS+e],
                             ring_vel[slot*DOFS+e], e == DOFS - 1));
  endtask

  task automatic ring_predict(beat_t b);
    int unsigned slot;
    bit          full;
    bit          hit;
    full = ring_count >= DEPTH;
    slot = (ring_oldest + ring_count) % DEPTH;
    hit  = 1'b0;
    case (b.op)
      OP_APPEND: begin
        if (!full && ring_fill < DOFS) begin
          ring_pos[slot*DOFS+ring_fill] = b.pos;
          ring_vel[slot*DOFS+ring_fill] = b.vel;
        end
        if (ring_fill < DOFS) ring_fill++;
        if (b.fin) begin
          if (full) begin
            queue_result(mk_result(STAT_FULL, '0, '0, '0, 1'b1));
          end else begin
            for (int unsigned k = ring_fill; k < DOFS; k++) begin
              ring_pos[slot*DOFS+k] = '0;
              ring_vel[slot*DOFS+k] = '0;
            end
            ring_time[slot] = b.stamp;
            ring_count++;
            queue_result(mk_result(STAT_OK, b.stamp, '0, '0, 1'b1));
          end
          ring_fill = 0;
        end
      end
      OP_QUERY, OP_DISCARD: begin
        if (ring_count == 0) begin
          queue_result(mk_result(STAT_EMPTY, '0, '0, '0, 1'b1));
        end else if (b.op == OP_QUERY) begin
          for (int k = ring_count; k > 0 && !hit; k--) begin
            slot = (ring_oldest + k - 1) % DEPTH;
            if (ring_time[slot] <= b.stamp) begin
              stream_entry(slot, STAT_OK);
              hit = 1'b1;
            end
          end
          if (!hit) stream_entry(ring_oldest, STAT_EARLY);
        end else begin
          for (int k = ring_count; k > 0 && !hit; k--) begin
            slot = (ring_oldest + k - 1) % DEPTH;
            if (ring_time[slot] < b.stamp) begin
              ring_oldest = (ring_oldest + k) % DEPTH;
              ring_count -= k;
              hit = 1'b1;
            end
          end
          queue_result(mk_result(STAT_OK, '0, '0, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return {(WORD_W/2){2'b10}};
      3:       return {(WORD_W/2){2'b01}};
      default: return rand_word();
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] next_stamp();
    if ($urandom_range(0, 9) == 0) return rand_word();
    stamp_clock = stamp_clock + WORD_W'($urandom_range(1, 500));
    return stamp_clock;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_stamp();
    logic signed [WORD_W-1:0] t;
    if (stamp_hist.size() == 0) return rand_word();
    t = stamp_hist[$urandom_range(0, stamp_hist.size() - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return t;
      4, 5:       return t + WORD_W'($urandom_range(0, 6)) - WORD_W'(3);
      6: begin
        case ($urandom_range(0, 3))
          0:       return T_MIN;
          1:       return T_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      7:          return rand_word();
      default:    return stamp_hist[0] - WORD_W'(1);
    endcase
  endfunction

  task automatic send(op_e op, logic signed [WORD_W-1:0] t, logic [WORD_W-1:0] p,
                      logic [WORD_W-1:0] v, logic fin);
    beat_t b;
    b.op    = op;
    b.stamp = t;
    b.pos   = p;
    b.vel   = v;
    b.fin   = fin;
    beats_to_send.insert(beats_to_send.size(), b);
  endtask

  task automatic send_entry(int n, logic signed [WORD_W-1:0] t);
    for (int i = 0; i < n; i++)
      send(OP_APPEND, (i == n - 1) ? t : rand_word(), pick_word(), pick_word(), i == n - 1);
    stamp_hist.insert(stamp_hist.size(), t);
    if (stamp_hist.size() > HIST_KEEP) void'(stamp_hist.pop_front());
  endtask

  task automatic flag_mismatch(string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // input driver
  always @(posedge clk_i) begin : drive_beats
    bit load;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        ring_predict(on_wire);
        load = 1'b1;
      end else begin
        load = !in_valid_i;
      end
      if (load) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          on_wire = beats_to_send.pop_front();
          in_valid_i      <= 1'b1;
          operation_i     <= on_wire.op;
          stamp_i         <= on_wire.stamp;
          position_word_i <= on_wire.pos;
          velocity_word_i <= on_wire.vel;
          final_element_i <= on_wire.fin;
          if (!calm_phase && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      calm_phase <= beats_to_send.size() < CALM_TAIL;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rx_stall > 0) rx_stall--;
    else if (!calm_phase && $urandom_range(0, 11) == 0) rx_stall = $urandom_range(1, 16);
    out_ready_i <= (rx_stall == 0);
  end

  // output monitor
  always @(posedge clk_i) begin : check_beats
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat st=%0d t=%h p=%h v=%h l=%b", status_o,
                                entry_stamp_o, position_out_o, velocity_out_o, last_out_o));
      end else begin
        want = results_due.pop_front();
        if (status_o !== want.status || entry_stamp_o !== want.stamp ||
            position_out_o !== want.pos || velocity_out_o !== want.vel ||
            last_out_o !== want.last)
          flag_mismatch($sformatf(
            "exp st=%0d t=%h p=%h v=%h l=%b / got st=%0d t=%h p=%h v=%h l=%b",
            want.status, want.stamp, want.pos, want.vel, want.last,
            status_o, entry_stamp_o, position_out_o, velocity_out_o, last_out_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int  rand_base;
    int  n_ignored;
    int  sel;
    int  n;
    bit  ring_filled;
    n_ignored   = 0;
    ring_filled = 1'b0;

    // empty ring, unknown operation
    send(OP_QUERY, '0, '0, '1, 1'b1);
    send(OP_DISCARD, T_MAX, '1, '0, 1'b0);
    send(OP_IGNORE, T_MIN, '1, '1, 1'b1);
    // overlong entry at the earliest time, extreme words
    for (int i = 0; i < DOFS + 2; i++)
      send(OP_APPEND, T_MIN, i[0] ? '1 : '0, i[0] ? '0 : '1, i == DOFS + 1);
    // query between elements of a partial entry
    send(OP_APPEND, '1, {(WORD_W/2){2'b10}}, {(WORD_W/2){2'b01}}, 1'b0);
    send(OP_QUERY, T_MIN, '0, '0, 1'b0);
    send(OP_APPEND, T_MAX, {(WORD_W/2){2'b01}}, {(WORD_W/2){2'b10}}, 1'b1);
    send(OP_APPEND, '0, '1, '1, 1'b1);
    send(OP_QUERY, T_MAX, '0, '0, 1'b0);
    send(OP_QUERY, '1, '0, '0, 1'b0);
    send(OP_DISCARD, '0, '0, '0, 1'b0);
    send(OP_QUERY, T_MIN, '0, '0, 1'b0);
    send(OP_DISCARD, T_MAX, '0, '0, 1'b0);
    send(OP_QUERY, '0, '0, '0, 1'b0);

    rand_base = beats_to_send.size();
    while (beats_to_send.size() - rand_base - n_ignored < RAND_BEATS) begin
      if (!ring_filled && beats_to_send.size() - rand_base > FILL_AFTER) begin
        for (int i = 0; i < DEPTH + 4; i++) send_entry(1, next_stamp());
        send_entry(3, next_stamp());
        send(OP_QUERY, pick_stamp(), rand_word(), rand_word(), 1'b0);
        send(OP_QUERY, T_MIN, rand_word(), rand_word(), 1'b1);
        ring_filled = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(DOFS + 1, DOFS + 3)
                                         : $urandom_range(1, DOFS);
        if (n > 1 && $urandom_range(0, 9) == 0) begin
          send(OP_APPEND, rand_word(), pick_word(), pick_word(), 1'b0);
          send($urandom_range(0, 1) ? OP_QUERY : OP_DISCARD, pick_stamp(),
               rand_word(), rand_word(), 1'b0);
          n--;
        end
        send_entry(n, next_stamp());
      end else if (sel < 75) begin
        send(OP_QUERY, pick_stamp(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
      end else if (sel < 88) begin
        send(OP_DISCARD, pick_stamp(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
      end else if (sel < 93) begin
        send(OP_IGNORE, rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
        n_ignored++;
      end else begin
        send(OP_QUERY, rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (beats_to_send.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
